// File: sv/pip_pkg.sv
// Shared types and constants of the point-in-polygon test unit.
// Used by pip_ctrl, pip_datapath and point_in_polygon_test_unit; depends on nothing.

package pip_pkg;

    localparam int COORD_BITS_DEF = 20;
    localparam int TOL_BITS       = 20;
    localparam int OUT_TDATA_W    = 8;
    localparam int OPD_COUNT      = 12;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CR0,
        ST_CR1,
        ST_LN0,
        ST_LN1,
        ST_S00,
        ST_S01,
        ST_WAIT,
        ST_DEC,
        ST_W0,
        ST_W1,
        ST_U0,
        ST_U1,
        ST_TOL,
        ST_X0,
        ST_X1,
        ST_X2,
        ST_X3,
        ST_X4,
        ST_DONE,
        ST_OUT
    } t_state;

    // Multiplier operand selection.
    typedef enum logic [3:0] {
        OPD_DX,
        OPD_DY,
        OPD_WX,
        OPD_WY,
        OPD_UX,
        OPD_UY,
        OPD_CR_HI,
        OPD_CR_LO,
        OPD_LEN_HI,
        OPD_LEN_LO,
        OPD_TOL,
        OPD_ONE
    } t_opnd;

    // Left shift applied to a product before it enters the accumulator.
    typedef enum logic [1:0] {
        SH_0,
        SH_MW,
        SH_MW1,
        SH_2MW
    } t_shift;

    // Which saved sum takes the accumulator result.
    typedef enum logic [1:0] {
        CAP_NONE,
        CAP_CR,
        CAP_LEN,
        CAP_S0
    } t_cap;

    typedef struct packed {
        logic   load_vtx;
        logic   load_first;
        logic   adv_prev;
        logic   closing;
        logic   mac_en;
        t_opnd  opa;
        t_opnd  opb;
        t_shift shift;
        logic   neg;
        logic   clr;
        t_cap   cap;
        logic   tst;
        logic   upd_par;
        logic   load_res;
    } t_dp_cmd;

    typedef struct packed {
        logic s0_le0;
        logic s0_ge_len;
    } t_dp_status;

endpackage

// File: sv/pip_datapath.sv
// Datapath of the point-in-polygon test unit: vertex registers, one shared
// multiplier with a signed accumulator, saved edge sums and the result flags.
// Depends on pip_pkg.

module pip_datapath #(
    parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic signed [COORD_BITS-1:0]  i_vertex_x,
    input  logic signed [COORD_BITS-1:0]  i_vertex_y,
    input  logic signed [COORD_BITS-1:0]  i_point_x,
    input  logic signed [COORD_BITS-1:0]  i_point_y,
    input  logic                          i_cfg_wr_en,
    input  logic [pip_pkg::TOL_BITS-1:0]  i_cfg_wr_data,
    input  pip_pkg::t_dp_cmd              i_cmd,
    output pip_pkg::t_dp_status           o_status,
    output logic                          o_inside_res,
    output logic                          o_on_boundary
);

    localparam int DW = COORD_BITS + 1;
    localparam int MW = (COORD_BITS + 1 > pip_pkg::TOL_BITS) ? COORD_BITS + 1
                                                             : pip_pkg::TOL_BITS;
    localparam int PW = 2 * MW;
    localparam int SW = 2 * MW + 2;
    localparam int AW = 4 * MW + 2;

    logic signed [COORD_BITS-1:0] r_cur_x, r_cur_y, r_prev_x, r_prev_y;
    logic signed [COORD_BITS-1:0] r_first_x, r_first_y, r_query_x, r_query_y;
    logic [pip_pkg::TOL_BITS-1:0] r_tol;
    logic                         r_parity, r_near, r_inside, r_onb;
    logic signed [SW-1:0]         r_cr, r_len, r_s0;
    logic signed [AW-1:0]         r_acc;

    logic [PW-1:0]                r_prod;
    logic                         r_p_vld, r_p_neg, r_p_clr, r_p_tst;
    pip_pkg::t_shift              r_p_sh;
    pip_pkg::t_cap                r_p_cap;

    logic signed [COORD_BITS-1:0] ax, ay, bx, by;
    logic signed [DW-1:0]         dx, dy, wx, wy, ux, uy;
    logic [SW-1:0]                cr_abs;
    logic [MW-1:0]                opnd_mag [pip_pkg::OPD_COUNT];
    logic                         opnd_sgn [pip_pkg::OPD_COUNT];
    logic [MW-1:0]                mul_a, mul_b;
    logic [AW-1:0]                prod_ext;
    logic signed [AW-1:0]         term, acc_base, acc_next;
    logic                         acc_le0, crosses, dy_pos, cr_pos, toggle;

    function automatic logic [MW-1:0] mag_of(input logic signed [DW-1:0] v);
        logic [DW-1:0] m;
        m = v[DW-1] ? DW'(-v) : DW'(v);
        return MW'(m);
    endfunction

    // Edge endpoints: a running edge goes from the current vertex to the
    // previous one, the closing edge from the first vertex to the current one.
    assign ax = i_cmd.closing ? r_first_x : r_cur_x;
    assign ay = i_cmd.closing ? r_first_y : r_cur_y;
    assign bx = i_cmd.closing ? r_cur_x   : r_prev_x;
    assign by = i_cmd.closing ? r_cur_y   : r_prev_y;

    assign dx = DW'(bx) - DW'(ax);
    assign dy = DW'(by) - DW'(ay);
    assign wx = DW'(r_query_x) - DW'(ax);
    assign wy = DW'(r_query_y) - DW'(ay);
    assign ux = DW'(r_query_x) - DW'(bx);
    assign uy = DW'(r_query_y) - DW'(by);

    assign cr_abs = r_cr[SW-1] ? SW'(-r_cr) : SW'(r_cr);

    always_comb begin
        opnd_mag[pip_pkg::OPD_DX]     = mag_of(dx);
        opnd_sgn[pip_pkg::OPD_DX]     = dx[DW-1];
        opnd_mag[pip_pkg::OPD_DY]     = mag_of(dy);
        opnd_sgn[pip_pkg::OPD_DY]     = dy[DW-1];
        opnd_mag[pip_pkg::OPD_WX]     = mag_of(wx);
        opnd_sgn[pip_pkg::OPD_WX]     = wx[DW-1];
        opnd_mag[pip_pkg::OPD_WY]     = mag_of(wy);
        opnd_sgn[pip_pkg::OPD_WY]     = wy[DW-1];
        opnd_mag[pip_pkg::OPD_UX]     = mag_of(ux);
        opnd_sgn[pip_pkg::OPD_UX]     = ux[DW-1];
        opnd_mag[pip_pkg::OPD_UY]     = mag_of(uy);
        opnd_sgn[pip_pkg::OPD_UY]     = uy[DW-1];
        opnd_mag[pip_pkg::OPD_CR_HI]  = cr_abs[2*MW-1:MW];
        opnd_sgn[pip_pkg::OPD_CR_HI]  = 1'b0;
        opnd_mag[pip_pkg::OPD_CR_LO]  = cr_abs[MW-1:0];
        opnd_sgn[pip_pkg::OPD_CR_LO]  = 1'b0;
        opnd_mag[pip_pkg::OPD_LEN_HI] = r_len[2*MW-1:MW];
        opnd_sgn[pip_pkg::OPD_LEN_HI] = 1'b0;
        opnd_mag[pip_pkg::OPD_LEN_LO] = r_len[MW-1:0];
        opnd_sgn[pip_pkg::OPD_LEN_LO] = 1'b0;
        opnd_mag[pip_pkg::OPD_TOL]    = MW'(r_tol);
        opnd_sgn[pip_pkg::OPD_TOL]    = 1'b0;
        opnd_mag[pip_pkg::OPD_ONE]    = MW'(1);
        opnd_sgn[pip_pkg::OPD_ONE]    = 1'b0;
    end

    assign mul_a = opnd_mag[i_cmd.opa];
    assign mul_b = opnd_mag[i_cmd.opb];

    // Accumulate stage: the registered product is shifted, signed and added.
    always_comb begin
        prod_ext = AW'(r_prod);
        case (r_p_sh)
            pip_pkg::SH_0:   term = prod_ext;
            pip_pkg::SH_MW:  term = prod_ext << MW;
            pip_pkg::SH_MW1: term = prod_ext << (MW + 1);
            pip_pkg::SH_2MW: term = prod_ext << (2 * MW);
            default:         term = prod_ext;
        endcase
        acc_base = r_p_clr ? '0 : r_acc;
        acc_next = r_p_neg ? acc_base - term : acc_base + term;
        acc_le0  = acc_next[AW-1] || (acc_next == '0);
    end

    // The ray toward +x crosses the edge when the endpoints straddle the
    // point's y and the cross product has the sign that dy calls for.
    assign crosses = (ay > r_query_y) != (by > r_query_y);
    assign dy_pos  = !dy[DW-1] && (dy != '0);
    assign cr_pos  = !r_cr[SW-1] && (r_cr != '0);
    assign toggle  = crosses && (dy_pos ? cr_pos : r_cr[SW-1]);

    assign o_status.s0_le0    = r_s0[SW-1] || (r_s0 == '0);
    assign o_status.s0_ge_len = r_s0 >= r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol    <= '0;
            r_p_vld  <= 1'b0;
            r_parity <= 1'b0;
            r_near   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_tol <= i_cfg_wr_data;
            end
            r_p_vld <= i_cmd.mac_en;
            if (i_cmd.load_first) begin
                r_parity <= 1'b0;
                r_near   <= 1'b0;
            end
            if (i_cmd.upd_par && toggle) begin
                r_parity <= !r_parity;
            end
            if (r_p_vld && r_p_tst && acc_le0) begin
                r_near <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_vtx) begin
            r_cur_x <= i_vertex_x;
            r_cur_y <= i_vertex_y;
        end
        if (i_cmd.load_first) begin
            r_first_x <= i_vertex_x;
            r_first_y <= i_vertex_y;
            r_prev_x  <= i_vertex_x;
            r_prev_y  <= i_vertex_y;
            r_query_x <= i_point_x;
            r_query_y <= i_point_y;
        end else if (i_cmd.adv_prev) begin
            r_prev_x <= r_cur_x;
            r_prev_y <= r_cur_y;
        end
        if (i_cmd.mac_en) begin
            r_prod  <= mul_a * mul_b;
            r_p_neg <= opnd_sgn[i_cmd.opa] ^ opnd_sgn[i_cmd.opb] ^ i_cmd.neg;
            r_p_sh  <= i_cmd.shift;
            r_p_clr <= i_cmd.clr;
            r_p_cap <= i_cmd.cap;
            r_p_tst <= i_cmd.tst;
        end
        if (r_p_vld) begin
            r_acc <= acc_next;
            case (r_p_cap)
                pip_pkg::CAP_CR:  r_cr  <= acc_next[SW-1:0];
                pip_pkg::CAP_LEN: r_len <= acc_next[SW-1:0];
                pip_pkg::CAP_S0:  r_s0  <= acc_next[SW-1:0];
                default: ;
            endcase
        end
        if (i_cmd.load_res) begin
            r_inside <= r_parity | r_near;
            r_onb    <= r_near;
        end
    end

    assign o_inside_res  = r_inside;
    assign o_on_boundary = r_onb;

endmodule

// File: sv/pip_ctrl.sv
// Controller of the point-in-polygon test unit: ring tracking, the per-edge
// multiply sequence and the output register handshake.
// Depends on pip_pkg.

module pip_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_valid,
    input  logic                i_s_last,
    output logic                o_s_ready,
    output logic                o_m_valid,
    input  logic                i_m_ready,
    input  pip_pkg::t_dp_status i_status,
    output pip_pkg::t_dp_cmd    o_cmd
);

    pip_pkg::t_state r_state, n_state;
    logic            r_in_ring, n_in_ring;
    logic            r_last, n_last;
    logic            r_closing, n_closing;
    logic            r_out_valid, n_out_valid;

    function automatic pip_pkg::t_dp_cmd mac_cmd(
        input pip_pkg::t_opnd  a,
        input pip_pkg::t_opnd  b,
        input pip_pkg::t_shift sh,
        input logic            ng,
        input logic            cl,
        input logic            cc
    );
        pip_pkg::t_dp_cmd c;
        c         = '0;
        c.closing = cc;
        c.mac_en  = 1'b1;
        c.opa     = a;
        c.opb     = b;
        c.shift   = sh;
        c.neg     = ng;
        c.clr     = cl;
        return c;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pip_pkg::ST_IDLE;
            r_in_ring   <= 1'b0;
            r_last      <= 1'b0;
            r_closing   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_ring   <= n_in_ring;
            r_last      <= n_last;
            r_closing   <= n_closing;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_in_ring   = r_in_ring;
        n_last      = r_last;
        n_closing   = r_closing;
        n_out_valid = r_out_valid && !i_m_ready;
        o_s_ready   = 1'b0;
        o_cmd       = '0;
        o_cmd.closing = r_closing;
        case (r_state)
            pip_pkg::ST_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.load_vtx   = 1'b1;
                    o_cmd.load_first = !r_in_ring;
                    n_last           = i_s_last;
                    n_in_ring        = 1'b1;
                    if (r_in_ring) begin
                        n_closing = 1'b0;
                        n_state   = pip_pkg::ST_CR0;
                    end else if (i_s_last) begin
                        // A lone vertex still forms the degenerate closing edge.
                        n_closing = 1'b1;
                        n_state   = pip_pkg::ST_CR0;
                    end
                end
            end
            pip_pkg::ST_CR0: begin
                o_cmd   = mac_cmd(pip_pkg::OPD_DX, pip_pkg::OPD_WY, pip_pkg::SH_0,
                                  1'b0, 1'b1, r_closing);
                n_state = pip_pkg::ST_CR1;
            end
            pip_pkg::ST_CR1: begin
                o_cmd     = mac_cmd(pip_pkg::OPD_DY, pip_pkg::OPD_WX, pip_pkg::SH_0,
                                    1'b1, 1'b0, r_closing);
                o_cmd.cap = pip_pkg::CAP_CR;
                n_state   = pip_pkg::ST_LN0;
            end
            pip_pkg::ST_LN0: begin
                o_cmd   = mac_cmd(pip_pkg::OPD_DX, pip_pkg::OPD_DX, pip_pkg::SH_0,
                                  1'b0, 1'b1, r_closing);
                n_state = pip_pkg::ST_LN1;
            end
            pip_pkg::ST_LN1: begin
                o_cmd     = mac_cmd(pip_pkg::OPD_DY, pip_pkg::OPD_DY, pip_pkg::SH_0,
                                    1'b0, 1'b0, r_closing);
                o_cmd.cap = pip_pkg::CAP_LEN;
                n_state   = pip_pkg::ST_S00;
            end
            pip_pkg::ST_S00: begin
                o_cmd   = mac_cmd(pip_pkg::OPD_WX, pip_pkg::OPD_DX, pip_pkg::SH_0,
                                  1'b0, 1'b1, r_closing);
                n_state = pip_pkg::ST_S01;
            end
            pip_pkg::ST_S01: begin
                o_cmd     = mac_cmd(pip_pkg::OPD_WY, pip_pkg::OPD_DY, pip_pkg::SH_0,
                                    1'b0, 1'b0, r_closing);
                o_cmd.cap = pip_pkg::CAP_S0;
                n_state   = pip_pkg::ST_WAIT;
            end
            pip_pkg::ST_WAIT: begin
                n_state = pip_pkg::ST_DEC;
            end
            pip_pkg::ST_DEC: begin
                // The projection falls before the start, past the end, or inside.
                o_cmd.upd_par = 1'b1;
                if (i_status.s0_le0) begin
                    n_state = pip_pkg::ST_W0;
                end else if (i_status.s0_ge_len) begin
                    n_state = pip_pkg::ST_U0;
                end else begin
                    n_state = pip_pkg::ST_X0;
                end
            end
            pip_pkg::ST_W0: begin
                o_cmd   = mac_cmd(pip_pkg::OPD_WX, pip_pkg::OPD_WX, pip_pkg::SH_0,
                                  1'b0, 1'b1, r_closing);
                n_state = pip_pkg::ST_W1;
            end
            pip_pkg::ST_W1: begin
                o_cmd   = mac_cmd(pip_pkg::OPD_WY, pip_pkg::OPD_WY, pip_pkg::SH_0,
                                  1'b0, 1'b0, r_closing);
                n_state = pip_pkg::ST_TOL;
            end
            pip_pkg::ST_U0: begin
                o_cmd   = mac_cmd(pip_pkg::OPD_UX, pip_pkg::OPD_UX, pip_pkg::SH_0,
                                  1'b0, 1'b1, r_closing);
                n_state = pip_pkg::ST_U1;
            end
            pip_pkg::ST_U1: begin
                o_cmd   = mac_cmd(pip_pkg::OPD_UY, pip_pkg::OPD_UY, pip_pkg::SH_0,
                                  1'b0, 1'b0, r_closing);
                n_state = pip_pkg::ST_TOL;
            end
            pip_pkg::ST_TOL: begin
                o_cmd     = mac_cmd(pip_pkg::OPD_TOL, pip_pkg::OPD_ONE, pip_pkg::SH_0,
                                    1'b1, 1'b0, r_closing);
                o_cmd.tst = 1'b1;
                n_state   = pip_pkg::ST_DONE;
            end
            pip_pkg::ST_X0: begin
                o_cmd   = mac_cmd(pip_pkg::OPD_CR_HI, pip_pkg::OPD_CR_HI, pip_pkg::SH_2MW,
                                  1'b0, 1'b1, r_closing);
                n_state = pip_pkg::ST_X1;
            end
            pip_pkg::ST_X1: begin
                // The cross term of the square counts twice, hence one extra shift.
                o_cmd   = mac_cmd(pip_pkg::OPD_CR_HI, pip_pkg::OPD_CR_LO, pip_pkg::SH_MW1,
                                  1'b0, 1'b0, r_closing);
                n_state = pip_pkg::ST_X2;
            end
            pip_pkg::ST_X2: begin
                o_cmd   = mac_cmd(pip_pkg::OPD_CR_LO, pip_pkg::OPD_CR_LO, pip_pkg::SH_0,
                                  1'b0, 1'b0, r_closing);
                n_state = pip_pkg::ST_X3;
            end
            pip_pkg::ST_X3: begin
                o_cmd   = mac_cmd(pip_pkg::OPD_TOL, pip_pkg::OPD_LEN_LO, pip_pkg::SH_0,
                                  1'b1, 1'b0, r_closing);
                n_state = pip_pkg::ST_X4;
            end
            pip_pkg::ST_X4: begin
                o_cmd     = mac_cmd(pip_pkg::OPD_TOL, pip_pkg::OPD_LEN_HI, pip_pkg::SH_MW,
                                    1'b1, 1'b0, r_closing);
                o_cmd.tst = 1'b1;
                n_state   = pip_pkg::ST_DONE;
            end
            pip_pkg::ST_DONE: begin
                if (r_closing) begin
                    n_state = pip_pkg::ST_OUT;
                end else begin
                    o_cmd.adv_prev = 1'b1;
                    if (r_last) begin
                        n_closing = 1'b1;
                        n_state   = pip_pkg::ST_CR0;
                    end else begin
                        n_state = pip_pkg::ST_IDLE;
                    end
                end
            end
            pip_pkg::ST_OUT: begin
                if (!r_out_valid || i_m_ready) begin
                    o_cmd.load_res = 1'b1;
                    n_out_valid    = 1'b1;
                    n_in_ring      = 1'b0;
                    n_state        = pip_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pip_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_m_valid = r_out_valid;

`ifndef SYNTHESIS
    a_res_after_closing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_res |-> (r_closing && (!r_out_valid || i_m_ready)))
        else $error("result loaded outside a closing edge or over a held result");

    a_done_after_test: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pip_pkg::ST_DONE) |->
            ($past(r_state) == pip_pkg::ST_TOL || $past(r_state) == pip_pkg::ST_X4))
        else $error("edge finished without a distance test");

    a_closing_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != pip_pkg::ST_IDLE && r_state != pip_pkg::ST_DONE) |=> $stable(r_closing))
        else $error("edge selection changed in the middle of an edge");
`endif

endmodule

// File: sv/point_in_polygon_test_unit.sv
// Top level of the point-in-polygon test unit: stream ports, field packing and
// the controller/datapath pair. Depends on pip_pkg, pip_ctrl and pip_datapath.
//
// Usage: the vertices of one closed ring arrive on the slave stream, one item
// each, with the query point (taken from the first vertex of a ring only) and
// tlast on the final vertex. Each ring produces one item on the master stream
// carrying inside_res and on_boundary. The tolerance register is written
// through i_cfg_wr_en / i_cfg_wr_data; the user must write it only while the
// unit is idle, which the unit itself does not enforce. Each edge runs through
// one shared multiplier, one product a cycle, with one distance test when the
// nearest point is an endpoint and another when it lies inside the segment.
// A vertex is taken only once the edge of the previous one is done. Every
// vertex but the first of a ring runs one edge; the last runs two (its own and
// the closing edge) and then loads the output register, which raises tvalid
// (a lone vertex has only the closing edge). Reset clears the ring tracking,
// the tolerance register and the output valid. A stalled receiver holds the
// result in the output register; the unit keeps taking vertices of the next
// ring and only waits at that ring's result.

module point_in_polygon_test_unit #(
    parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // vertex_x, vertex_y, point_x, point_y, then zero padding
    input  logic [((4*COORD_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    // last_vertex
    input  logic                             i_s_axis_tlast,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // inside_res, on_boundary, then zero padding
    output logic [pip_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    input  logic                             i_cfg_wr_en,
    input  logic [pip_pkg::TOL_BITS-1:0]     i_cfg_wr_data
);

    pip_pkg::t_dp_cmd    cmd;
    pip_pkg::t_dp_status status;
    logic                inside_res, on_boundary;

    pip_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_s_last  (i_s_axis_tlast),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    pip_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_vertex_x    (i_s_axis_tdata[COORD_BITS-1:0]),
        .i_vertex_y    (i_s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_point_x     (i_s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .i_point_y     (i_s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS]),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_inside_res  (inside_res),
        .o_on_boundary (on_boundary)
    );

    assign o_m_axis_tdata = {{(pip_pkg::OUT_TDATA_W-2){1'b0}}, on_boundary, inside_res};

endmodule
